// ===== hw/rtl/doubly_linked_list_cursor_engine_top_defines.svh =====
// Assertion helpers for the linked list cursor engine.
`ifndef DOUBLY_LINKED_LIST_CURSOR_ENGINE_TOP_DEFINES_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ENGINE_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DLL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define DLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dllce_pkg.sv =====
// ----------------------------------------------------------------------------
// dllce_pkg
// Shared types and operation codes of the linked list cursor engine.
// ----------------------------------------------------------------------------
package dllce_pkg;

  typedef enum logic [4:0] {
    OP_DISPOSE    = 5'd0,
    OP_INS_FIRST  = 5'd1,
    OP_INS_LAST   = 5'd2,
    OP_FIRST      = 5'd3,
    OP_LAST       = 5'd4,
    OP_GET_FIRST  = 5'd5,
    OP_GET_LAST   = 5'd6,
    OP_DEL_FIRST  = 5'd7,
    OP_DEL_LAST   = 5'd8,
    OP_DEL_AFTER  = 5'd9,
    OP_DEL_BEFORE = 5'd10,
    OP_INS_AFTER  = 5'd11,
    OP_INS_BEFORE = 5'd12,
    OP_GET        = 5'd13,
    OP_SET        = 5'd14,
    OP_NEXT       = 5'd15,
    OP_PREV       = 5'd16,
    OP_IS_ACTIVE  = 5'd17
  } op_t;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               error;
    logic               cursor_active;
  } rsp_t;

endpackage

// ===== hw/rtl/doubly_linked_list_cursor_engine_top.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine_top
// Bounded doubly linked list with one cursor, kept in a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one operation code and
//   a value per transfer. Output channel (out_valid/out_ready/out_data)
//   returns exactly one result per operation, in order.
//   One operation is worked on at a time. Pool links and values live in three
//   single-port-read memories with registered read data; the sequencer walks
//   through dependent reads (cursor link, then neighbor link / free list) and
//   writes. Pointer-only operations go from RD1 to DONE; an end insert into a
//   non-empty list adds RD3, a del_last that leaves a list behind adds RD4,
//   and a middle insert or delete passes RD2, RD3 and RD4 in turn. A new
//   transfer is taken only once the sequencer is back in IDLE and the output
//   register has drained.
//   Reset clears head, tail, cursor, free list head and the fresh counter at
//   once; pool memories are never cleared (an unwritten entry's data is never used).
//   When the receiver stalls the result waits in the output register; the
//   engine takes the next operation as soon as that register is free.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_cursor_engine_top_defines.svh"

module doubly_linked_list_cursor_engine_top #(
  parameter int NODES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dllce_pkg::req_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dllce_pkg::rsp_t    out_data
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int IW = $clog2(NODES + 1);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_RD4, S_DONE
  } state_t;

  state_t state;
  dllce_pkg::op_t op;
  logic signed [31:0] data;
  logic [IW-1:0] head, tail, cur, free_head, fresh;
  logic [IW-1:0] d_ix, x_ix;
  logic [31:0] rd_val;
  logic err;

  // memory ports
  logic          nx_we, pv_we, vl_we;
  logic [AW-1:0] nx_wa, pv_wa, vl_wa, nx_ra, pv_ra, vl_ra;
  logic [IW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [31:0]   vl_wd, vl_rd;

  dllce_link_mem #(.WIDTH(IW), .DEPTH(NODES)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  dllce_link_mem #(.WIDTH(IW), .DEPTH(NODES)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  dllce_link_mem #(.WIDTH(32), .DEPTH(NODES)) u_val (
    .clk, .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));

  function automatic logic okf(logic [IW-1:0] ix);
    okf = (ix < NIL);
  endfunction

  function automatic logic [AW-1:0] ad(logic [IW-1:0] ix);
    ad = ix[AW-1:0];
  endfunction

  // Node an insert takes: free list first, then the fresh counter.
  logic [IW-1:0] take_ix;
  assign take_ix = okf(free_head) ? free_head : (fresh < NIL) ? fresh : NIL;

  // Node a get reads.
  logic [IW-1:0] get_ix;
  assign get_ix = (op == dllce_pkg::OP_GET_FIRST) ? head :
                  (op == dllce_pkg::OP_GET_LAST) ? tail : cur;

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic is_ins;
  assign is_ins = (op == dllce_pkg::OP_INS_FIRST) || (op == dllce_pkg::OP_INS_LAST) ||
                  (op == dllce_pkg::OP_INS_AFTER) || (op == dllce_pkg::OP_INS_BEFORE);

  // Read addresses: memories are read in the cycle after issue.
  // RD1 issue: cursor links / value of head/tail/cursor / free list pop.
  always_comb begin
    nx_ra = ad(cur);
    pv_ra = ad(cur);
    vl_ra = ad(cur);
    if (state == S_IDLE) begin
      case (dllce_pkg::op_t'(in_data.func))
        dllce_pkg::OP_GET_FIRST, dllce_pkg::OP_DEL_FIRST: begin
          vl_ra = ad(head);
          nx_ra = ad(head);
        end
        dllce_pkg::OP_GET_LAST, dllce_pkg::OP_DEL_LAST: begin
          vl_ra = ad(tail);
          pv_ra = ad(tail);
        end
        dllce_pkg::OP_INS_FIRST, dllce_pkg::OP_INS_LAST: nx_ra = ad(free_head);
        default: ;
      endcase
    end else if (state == S_RD2) begin
      // second link: neighbor of d, or free list pop for middle insert
      nx_ra = ad(is_ins ? free_head : d_ix);
      pv_ra = ad(d_ix);
    end
  end

  // Sequencer; an insert pops free_head to next[free_head], else bumps fresh.
  always_ff @(posedge clk) begin
    nx_we <= 1'b0;
    pv_we <= 1'b0;
    vl_we <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op     <= dllce_pkg::op_t'(in_data.func);
            data   <= in_data.data_value;
            rd_val <= '0;
            err    <= 1'b0;
            state  <= S_RD1;
          end
        end
        S_RD1: begin
          // first read data available
          state <= S_DONE;
          case (op)
            dllce_pkg::OP_DISPOSE: begin
              if (okf(head) && okf(tail)) begin
                nx_we <= 1'b1; nx_wa <= ad(tail); nx_wd <= free_head;
                free_head <= head;
              end
              head <= NIL; tail <= NIL; cur <= NIL;
            end
            dllce_pkg::OP_INS_FIRST, dllce_pkg::OP_INS_LAST: begin
              if (!okf(take_ix)) begin
                err <= 1'b1;
              end else begin
                if (okf(free_head)) free_head <= nx_rd;
                else fresh <= fresh + 1'b1;
                vl_we <= 1'b1; vl_wa <= ad(take_ix); vl_wd <= data;
                nx_we <= 1'b1; nx_wa <= ad(take_ix);
                pv_we <= 1'b1; pv_wa <= ad(take_ix);
                if (op == dllce_pkg::OP_INS_FIRST) begin
                  pv_wd <= NIL; nx_wd <= head; head <= take_ix;
                  if (!okf(head)) tail <= take_ix;
                  else begin x_ix <= head; d_ix <= take_ix; state <= S_RD3; end
                end else begin
                  nx_wd <= NIL; pv_wd <= tail; tail <= take_ix;
                  if (!okf(tail)) head <= take_ix;
                  else begin x_ix <= tail; d_ix <= take_ix; state <= S_RD3; end
                end
              end
            end
            dllce_pkg::OP_FIRST: cur <= head;
            dllce_pkg::OP_LAST:  cur <= tail;
            dllce_pkg::OP_GET_FIRST, dllce_pkg::OP_GET_LAST, dllce_pkg::OP_GET: begin
              if (okf(get_ix)) rd_val <= vl_rd;
              else err <= 1'b1;
            end
            dllce_pkg::OP_DEL_FIRST: begin
              if (okf(head)) begin
                if (cur == head) cur <= NIL;
                head <= nx_rd;
                nx_we <= 1'b1; nx_wa <= ad(head); nx_wd <= free_head;
                free_head <= head;
                if (okf(nx_rd)) begin
                  pv_we <= 1'b1; pv_wa <= ad(nx_rd); pv_wd <= NIL;
                end else tail <= NIL;
              end
            end
            dllce_pkg::OP_DEL_LAST: begin
              if (okf(tail)) begin
                if (cur == tail) cur <= NIL;
                tail <= pv_rd;
                if (okf(pv_rd)) begin
                  nx_we <= 1'b1; nx_wa <= ad(pv_rd); nx_wd <= NIL;
                  // free link of the dropped tail is written next cycle
                  x_ix <= tail; state <= S_RD4;
                end else begin
                  head <= NIL;
                  nx_we <= 1'b1; nx_wa <= ad(tail); nx_wd <= free_head;
                  free_head <= tail;
                end
              end
            end
            dllce_pkg::OP_DEL_AFTER, dllce_pkg::OP_INS_AFTER: begin
              if (okf(cur)) begin
                if (op == dllce_pkg::OP_INS_AFTER || okf(nx_rd)) begin
                  d_ix <= nx_rd; state <= S_RD2;
                end
              end
            end
            dllce_pkg::OP_DEL_BEFORE, dllce_pkg::OP_INS_BEFORE: begin
              if (okf(cur)) begin
                if (op == dllce_pkg::OP_INS_BEFORE || okf(pv_rd)) begin
                  d_ix <= pv_rd; state <= S_RD2;
                end
              end
            end
            dllce_pkg::OP_SET: begin
              if (okf(cur)) begin
                vl_we <= 1'b1; vl_wa <= ad(cur); vl_wd <= data;
              end
            end
            dllce_pkg::OP_NEXT: if (okf(cur)) cur <= nx_rd;
            dllce_pkg::OP_PREV: if (okf(cur)) cur <= pv_rd;
            default: ;
          endcase
        end
        S_RD2: begin
          // read of d's links (delete) or free pop (insert) issued this cycle
          state <= S_RD3;
        end
        S_RD3: begin
          state <= S_DONE;
          case (op)
            dllce_pkg::OP_INS_FIRST: begin
              pv_we <= 1'b1; pv_wa <= ad(x_ix); pv_wd <= d_ix;
            end
            dllce_pkg::OP_INS_LAST: begin
              nx_we <= 1'b1; nx_wa <= ad(x_ix); nx_wd <= d_ix;
            end
            dllce_pkg::OP_DEL_AFTER: begin
              // d = next[c], x = next[d]
              nx_we <= 1'b1; nx_wa <= ad(cur); nx_wd <= nx_rd;
              if (okf(nx_rd)) begin
                pv_we <= 1'b1; pv_wa <= ad(nx_rd); pv_wd <= cur;
              end else tail <= cur;
              x_ix <= d_ix; state <= S_RD4;
            end
            dllce_pkg::OP_DEL_BEFORE: begin
              pv_we <= 1'b1; pv_wa <= ad(cur); pv_wd <= pv_rd;
              if (okf(pv_rd)) begin
                nx_we <= 1'b1; nx_wa <= ad(pv_rd); nx_wd <= cur;
              end else head <= cur;
              x_ix <= d_ix; state <= S_RD4;
            end
            default: begin
              // middle insert; d_ix holds the cursor's neighbor
              if (!okf(take_ix)) begin
                err <= 1'b1;
              end else begin
                if (okf(free_head)) free_head <= nx_rd;
                else fresh <= fresh + 1'b1;
                vl_we <= 1'b1; vl_wa <= ad(take_ix); vl_wd <= data;
                nx_we <= 1'b1; nx_wa <= ad(take_ix);
                pv_we <= 1'b1; pv_wa <= ad(take_ix);
                x_ix <= take_ix;
                state <= S_RD4;
                if (op == dllce_pkg::OP_INS_AFTER) begin
                  pv_wd <= cur; nx_wd <= d_ix;
                  if (!okf(d_ix)) tail <= take_ix;
                end else begin
                  nx_wd <= cur; pv_wd <= d_ix;
                  if (!okf(d_ix)) head <= take_ix;
                end
              end
            end
          endcase
        end
        S_RD4: begin
          state <= S_DONE;
          case (op)
            dllce_pkg::OP_INS_AFTER: begin
              nx_we <= 1'b1; nx_wa <= ad(cur); nx_wd <= x_ix;
              if (okf(d_ix)) begin
                pv_we <= 1'b1; pv_wa <= ad(d_ix); pv_wd <= x_ix;
              end
            end
            dllce_pkg::OP_INS_BEFORE: begin
              pv_we <= 1'b1; pv_wa <= ad(cur); pv_wd <= x_ix;
              if (okf(d_ix)) begin
                nx_we <= 1'b1; nx_wa <= ad(d_ix); nx_wd <= x_ix;
              end
            end
            default: begin
              // push the removed node onto the free list
              nx_we <= 1'b1; nx_wa <= ad(x_ix); nx_wd <= free_head;
              free_head <= x_ix;
            end
          endcase
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_data.read_value    <= rd_val;
          out_data.error         <= err;
          out_data.cursor_active <= okf(cur);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result is only raised from the final step of a sequence.
  `DLL_ASSERT_NEXT(a_done_raises, (state == S_DONE), out_valid, "result not raised")
  `DLL_ASSERT_IMPL(a_busy_not_ready, (state != S_IDLE), !in_ready, "ready while busy")
  `DLL_ASSERT_IMPL(a_fresh_bound, 1'b1, fresh <= NIL, "fresh counter overflow")
  `DLL_ASSERT_IMPL(a_head_tail, 1'b1, okf(head) == okf(tail), "head/tail null mismatch")

endmodule

// ===== hw/rtl/dllce_link_mem.sv =====
// ----------------------------------------------------------------------------
// dllce_link_mem
// Node pool memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dllce_link_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
